/* hdl/rsa_unhash_chain_decryptor_macros.svh */
// assertion macros shared by the decryptor rtl
// no dependencies; included by the files that carry concurrent checks
`ifndef RSA_UNHASH_CHAIN_DECRYPTOR_MACROS_SVH
`define RSA_UNHASH_CHAIN_DECRYPTOR_MACROS_SVH

// antecedent implies consequent in the same cycle
`define RUHC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ruhc check failed");

// antecedent implies consequent in the next cycle
`define RUHC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ruhc check failed");

`endif

/* hdl/ruhc_pkg.sv */
// shared constants, types and substitution table of the unhash chain decryptor
// no dependencies; used by ruhc_modmul, ruhc_modexp and the top level
package ruhc_pkg;

  localparam int WORD_BITS   = 32;
  localparam int PROD_W      = 2 * WORD_BITS;
  localparam int TABLE_SIZE  = 128;
  localparam int TABLE_IDX_W = $clog2(TABLE_SIZE);
  localparam int CHAR_W      = 8;
  localparam int CFG_IDX_W   = 2;

  // register indexes of the config port
  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE    = 2'd2;

  localparam logic [WORD_BITS-1:0] EXPONENT_RESET = '0;
  localparam logic [WORD_BITS-1:0] MODULUS_RESET  = WORD_BITS'(2);
  localparam logic [WORD_BITS-1:0] NONCE_RESET    = '0;

  localparam logic [CHAR_W-1:0] SUBST_TABLE [TABLE_SIZE] = '{
    8'd110, 8'd77,  8'd85,  8'd93,  8'd101, 8'd118, 8'd89,  8'd126, 8'd111, 8'd115, 8'd92,
    8'd116, 8'd127, 8'd114, 8'd82,  8'd96,  8'd108, 8'd75,  8'd121, 8'd81,  8'd117,
    8'd78,  8'd73,  8'd94,  8'd104, 8'd95,  8'd102, 8'd125, 8'd71,  8'd80,  8'd100,
    8'd76,  8'd112, 8'd124, 8'd109, 8'd90,  8'd68,  8'd123, 8'd113, 8'd86,  8'd105,
    8'd83,  8'd91,  8'd122, 8'd103, 8'd72,  8'd106, 8'd87,  8'd70,  8'd120, 8'd69,
    8'd119, 8'd107, 8'd99,  8'd67,  8'd79,  8'd98,  8'd88,  8'd74,  8'd84,  8'd97,
    8'd66,  8'd65,  8'd64,  8'd63,  8'd62,
    8'd61,  8'd54,  8'd36,  8'd50,  8'd48,
    8'd28,  8'd45,  8'd22,  8'd58,  8'd17,  8'd31,  8'd1,   8'd21,  8'd55,  8'd29,
    8'd19,  8'd14,  8'd41,  8'd59,  8'd2,   8'd39,  8'd47,  8'd57,  8'd6,   8'd35,
    8'd42,  8'd10,  8'd3,   8'd23,  8'd25,  8'd15,  8'd60,  8'd56,  8'd53,  8'd30,
    8'd4,   8'd26,  8'd44,  8'd24,  8'd40,  8'd46,  8'd52,  8'd16,  8'd34,  8'd0,
    8'd8,   8'd32,  8'd38,  8'd13,  8'd9,   8'd11,  8'd20,  8'd5,   8'd51,  8'd49,
    8'd18,  8'd43,  8'd37,  8'd33,  8'd27,  8'd7,   8'd12
  };

  // status of the exponentiation sequencer toward the top level
  typedef struct packed {
    logic busy;
    logic done;
  } exp_stat_t;

endpackage

/* hdl/rsa_unhash_chain_decryptor.sv */
// top level: config registers, input/output stream handshakes, chain and table lookup
// depends on ruhc_pkg, ruhc_modexp and rsa_unhash_chain_decryptor_macros.svh
//
//   port group   dir  contents
//   s_axis_*     in   cipher words, tlast = end of message
//   m_axis_*     out  plain char and plain value, tuser = index fault, tlast = end of message
//   cfg_*        in   exponent, modulus, nonce writes
//
// per word the sequencer runs one modular multiply for each set exponent bit and one square for each
// exponent bit below the top set bit before the next input transfer
// each modular multiply holds the sequencer through the one-bit-per-cycle 64-by-32 reduction in the
// shared multiplier; a zero exponent runs no multiply; input not ready meanwhile
// the result sits in an output register, and a stalled output holds the next word at its end
// rst is synchronous; it clears the handshakes and the chain and sets the config registers to their reset values
`include "rsa_unhash_chain_decryptor_macros.svh"

module rsa_unhash_chain_decryptor (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ruhc_pkg::WORD_BITS-1:0]    s_axis_tdata,   // cipher_word
  input  logic                              s_axis_tlast,   // message_end
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ruhc_pkg::CHAR_W+ruhc_pkg::WORD_BITS-1:0]
                                            m_axis_tdata,   // plain_char, plain_value
  output logic                              m_axis_tuser,   // index_fault
  output logic                              m_axis_tlast,   // last_char
  input  logic                              cfg_wen,
  input  logic [ruhc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ruhc_pkg::WORD_BITS-1:0]    cfg_data
);

  localparam int W  = ruhc_pkg::WORD_BITS;
  localparam int CW = ruhc_pkg::CHAR_W;
  localparam int IW = ruhc_pkg::TABLE_IDX_W;

  typedef enum logic [1:0] {T_IDLE, T_BUSY, T_EMIT} top_state_t;

  top_state_t  state;
  logic [W-1:0] private_exponent;
  logic [W-1:0] modulus;
  logic [W-1:0] session_nonce;
  logic [W-1:0] chain_value;
  logic         at_message_start;
  logic         last_reg;
  logic [W-1:0] plain;

  logic [CW-1:0] out_char;
  logic [W-1:0]  out_plain;
  logic          out_fault;

  ruhc_pkg::exp_stat_t exp_stat;
  logic [W-1:0]        exp_result;
  logic                in_xfer;
  logic                out_free;
  logic                fault;
  logic [W-1:0]        chain_sel;
  logic [CW-1:0]       char_val;

  assign s_axis_tready = (state == T_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata  = {out_plain, out_char};
  assign m_axis_tuser  = out_fault;

  always_comb begin
    fault     = (plain[W-1:IW] != '0);
    chain_sel = at_message_start ? session_nonce : chain_value;
    char_val  = fault ? '0 : (ruhc_pkg::SUBST_TABLE[plain[IW-1:0]] ^ chain_sel[CW-1:0]);
  end

  ruhc_modexp u_modexp (
    .clk     (clk),
    .rst     (rst),
    .start   (in_xfer),
    .base_in (s_axis_tdata),
    .exp_in  (private_exponent),
    .m_in    (modulus),
    .stat    (exp_stat),
    .result  (exp_result)
  );

  // config writes; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      private_exponent <= ruhc_pkg::EXPONENT_RESET;
      modulus          <= ruhc_pkg::MODULUS_RESET;
      session_nonce    <= ruhc_pkg::NONCE_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        ruhc_pkg::CFG_EXPONENT: private_exponent <= cfg_data;
        ruhc_pkg::CFG_MODULUS:  modulus          <= cfg_data;
        ruhc_pkg::CFG_NONCE:    session_nonce    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= T_IDLE;
      m_axis_tvalid    <= 1'b0;
      chain_value      <= '0;
      at_message_start <= 1'b1;
    end else begin
      // in the emit state a taken transfer is refilled below
      if (m_axis_tvalid && m_axis_tready && (state != T_EMIT)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (in_xfer) begin
            last_reg <= s_axis_tlast;
            state    <= T_BUSY;
          end
        end
        T_BUSY: begin
          if (exp_stat.done) begin
            plain <= exp_result;
            state <= T_EMIT;
          end
        end
        T_EMIT: begin
          if (out_free) begin
            m_axis_tvalid    <= 1'b1;
            out_char         <= char_val;
            out_plain        <= plain;
            out_fault        <= fault;
            m_axis_tlast     <= last_reg;
            chain_value      <= plain;
            at_message_start <= last_reg;
            state            <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  `RUHC_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_xfer, exp_stat.busy && !s_axis_tready)
  `RUHC_ASSERT_IMPLY(a_done_while_busy, clk, rst, exp_stat.done, state == T_BUSY)
  `RUHC_ASSERT_IMPLY(a_fault_zero_char, clk, rst, m_axis_tvalid && out_fault, out_char == '0)
  `RUHC_ASSERT_IMPLY(a_fault_matches, clk, rst, m_axis_tvalid, out_fault == (out_plain[W-1:IW] != '0))

endmodule

/* hdl/ruhc_modmul.sv */
// shared modular multiplier: one 32x32 product, then a bit-serial 64-by-32 reduction
// depends on ruhc_pkg
module ruhc_modmul (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ruhc_pkg::WORD_BITS-1:0] a,
  input  logic [ruhc_pkg::WORD_BITS-1:0] b,
  input  logic [ruhc_pkg::WORD_BITS-1:0] m,
  output logic                           done,
  output logic [ruhc_pkg::WORD_BITS-1:0] result
);

  localparam int W     = ruhc_pkg::WORD_BITS;
  localparam int PW    = ruhc_pkg::PROD_W;
  localparam int CNT_W = $clog2(PW);

  typedef enum logic [1:0] {MM_IDLE, MM_REDUCE, MM_DONE} mm_state_t;

  mm_state_t      state;
  logic [PW-1:0]  prod;
  logic [W-1:0]   m_reg;
  logic [W-1:0]   rem;
  logic [CNT_W-1:0] cnt;

  logic [W:0]     rem_shift;
  logic [W:0]     rem_sub;
  logic [W-1:0]   rem_next;
  logic           m_small;

  // one restoring step: bring in the next product bit, subtract if it fits
  always_comb begin
    rem_shift = {rem, prod[PW-1]};
    rem_sub   = rem_shift - {1'b0, m_reg};
    rem_next  = (rem_shift >= {1'b0, m_reg}) ? rem_sub[W-1:0] : rem_shift[W-1:0];
    m_small   = (m_reg < W'(2));
  end

  assign done = (state == MM_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MM_IDLE;
    end else begin
      unique case (state)
        MM_IDLE: begin
          if (start) begin
            prod  <= PW'(a) * PW'(b);
            m_reg <= m;
            rem   <= '0;
            cnt   <= '0;
            state <= MM_REDUCE;
          end
        end
        MM_REDUCE: begin
          prod <= prod << 1;
          rem  <= rem_next;
          cnt  <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(PW - 1)) begin
            // modulus of zero or one reduces everything to zero
            result <= m_small ? '0 : rem_next;
            state  <= MM_DONE;
          end
        end
        MM_DONE: begin
          state <= MM_IDLE;
        end
        default: state <= MM_IDLE;
      endcase
    end
  end

endmodule

/* hdl/ruhc_modexp.sv */
// right-to-left square and multiply sequencer around one shared modular multiplier
// depends on ruhc_pkg and ruhc_modmul
module ruhc_modexp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ruhc_pkg::WORD_BITS-1:0] base_in,
  input  logic [ruhc_pkg::WORD_BITS-1:0] exp_in,
  input  logic [ruhc_pkg::WORD_BITS-1:0] m_in,
  output ruhc_pkg::exp_stat_t            stat,
  output logic [ruhc_pkg::WORD_BITS-1:0] result
);

  localparam int W = ruhc_pkg::WORD_BITS;

  typedef enum logic [2:0] {
    EX_IDLE, EX_CHECK, EX_MUL, EX_SHIFT, EX_SQR, EX_FINISH
  } ex_state_t;

  ex_state_t   state;
  logic [W-1:0] base;
  logic [W-1:0] acc;
  logic [W-1:0] ex;
  logic [W-1:0] m_reg;

  logic         mm_start;
  logic [W-1:0] mm_a;
  logic         mm_done;
  logic [W-1:0] mm_result;
  logic [W-1:0] ex_shift;

  always_comb begin
    ex_shift = ex >> 1;
    mm_start = ((state == EX_CHECK) && (ex != '0) && ex[0]) ||
               ((state == EX_SHIFT) && (ex_shift != '0));
    // multiply step uses acc * base, square step base * base
    mm_a     = (state == EX_CHECK) ? acc : base;
  end

  ruhc_modmul u_modmul (
    .clk    (clk),
    .rst    (rst),
    .start  (mm_start),
    .a      (mm_a),
    .b      (base),
    .m      (m_reg),
    .done   (mm_done),
    .result (mm_result)
  );

  assign stat.busy = (state != EX_IDLE);
  assign stat.done = (state == EX_FINISH);
  assign result    = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= EX_IDLE;
    end else begin
      unique case (state)
        EX_IDLE: begin
          if (start) begin
            base  <= base_in;
            ex    <= exp_in;
            m_reg <= m_in;
            acc   <= W'(1);
            state <= EX_CHECK;
          end
        end
        EX_CHECK: begin
          if (ex == '0) begin
            state <= EX_FINISH;
          end else if (ex[0]) begin
            state <= EX_MUL;
          end else begin
            state <= EX_SHIFT;
          end
        end
        EX_MUL: begin
          if (mm_done) begin
            acc   <= mm_result;
            state <= EX_SHIFT;
          end
        end
        EX_SHIFT: begin
          ex <= ex_shift;
          // no square after the top exponent bit
          if (ex_shift != '0) begin
            state <= EX_SQR;
          end else begin
            state <= EX_FINISH;
          end
        end
        EX_SQR: begin
          if (mm_done) begin
            base  <= mm_result;
            state <= EX_CHECK;
          end
        end
        EX_FINISH: begin
          state <= EX_IDLE;
        end
        default: state <= EX_IDLE;
      endcase
    end
  end

endmodule
